// ===== sv/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// Neural activation unit package
// Shared widths, codes, stage word types and the constant tanh breakpoint
// table for the activation pipeline.
// ----------------------------------------------------------------------------
package nau_pkg;

   localparam int DATA_WIDTH     = 16;
   localparam int FRAC_BITS      = 12;
   localparam int TABLE_SEGMENTS = 64;

   // Segment index and breakpoint geometry.
   localparam int SEG_W     = $clog2(TABLE_SEGMENTS);
   localparam int IDX_W     = SEG_W + 1;
   localparam int SEG_SHIFT = DATA_WIDTH - 1 - SEG_W;

   // Datapath widths.
   localparam int MAG_W        = DATA_WIDTH;
   localparam int FRAC_W       = SEG_SHIFT + 2;
   localparam int TAB_W        = FRAC_BITS + 1;
   localparam int SLOPE_PROD_W = TAB_W + FRAC_W;
   localparam int LEAK_PROD_W  = MAG_W + TAB_W;
   localparam int LEAK_W       = DATA_WIDTH - 1;
   localparam int SQ_PROD_W    = 2 * TAB_W;
   localparam int RES_W        = DATA_WIDTH + 2;

   localparam int PIPE_LATENCY = 5;

   localparam logic [TAB_W-1:0] FIX_ONE   = TAB_W'(2 ** FRAC_BITS);
   localparam logic [TAB_W-1:0] LEAKY     = TAB_W'((2 ** FRAC_BITS + 5) / 10);
   localparam logic [TAB_W-1:0] FIX_HALF  = TAB_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [RES_W-1:0] SAT_MAX =
      RES_W'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
   localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

   localparam longint Q30_ONE   = longint'(1) <<< 30;
   localparam longint E_INV_Q30 = 395007543;

   typedef enum logic [2:0] {
      KIND_TANH    = 3'd0,
      KIND_SIGMOID = 3'd1,
      KIND_RELU    = 3'd2,
      KIND_LEAKY   = 3'd3,
      KIND_LINEAR  = 3'd4
   } kind_type;

   typedef enum logic {
      OP_VALUE = 1'b0,
      OP_DERIV = 1'b1
   } op_type;

   // Control that travels alongside each word through the pipeline.
   typedef struct packed {
      kind_type                      kind;
      op_type                        op;
      logic                          neg;
      logic signed [DATA_WIDTH-1:0]  x;
   } item_ctl_type;

   // Word handed from the interpolation stages to the output stages.
   typedef struct packed {
      logic               valid;
      item_ctl_type       ctl;
      logic [TAB_W-1:0]   t_mag;
      logic [TAB_W-1:0]   sig;
      logic [LEAK_W-1:0]  leak;
   } interp_out_type;

   typedef logic [TAB_W-1:0] tanh_tab_type [0:TABLE_SEGMENTS];

   // Truncating quotient of two non-negative values by long division; it is
   // only ever evaluated while the table below is built.
   function automatic longint quotient_u(input longint a, input longint b);
      longint q;
      longint rem;
      q   = 0;
      rem = 0;
      for (int b_pos = 62; b_pos >= 0; b_pos--) begin
         rem = (rem <<< 1) | ((a >>> b_pos) & longint'(1));
         if (rem >= b) begin
            rem = rem - b;
            q   = q | (longint'(1) <<< b_pos);
         end
      end
      return q;
   endfunction

   // Evaluated once at elaboration: tanh at each breakpoint, built from
   // exp(-2b) in Q30, with a series for the fraction and repeated
   // multiplication by 1/e for the whole part.
   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type tab;
      longint bpt;
      longint u;
      longint n;
      longint f;
      longint sum;
      longint term;
      longint e;
      longint num;
      longint den;
      for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
         bpt = (longint'(i) * (longint'(1) <<< (DATA_WIDTH - 1))) / TABLE_SEGMENTS;
         u   = 2 * bpt;
         n   = u >>> FRAC_BITS;
         f   = u & ((longint'(1) <<< FRAC_BITS) - 1);
         if (n >= 64) begin
            e = 0;
         end else begin
            sum  = Q30_ONE;
            term = Q30_ONE;
            for (int k = 1; k <= 20; k++) begin
               term = quotient_u((term * f) >>> FRAC_BITS, longint'(k));
               if ((k & 1) == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
            for (longint j = 0; j < n; j++) begin
               sum = (sum * E_INV_Q30 + (Q30_ONE >>> 1)) >>> 30;
            end
            e = sum;
         end
         num    = (Q30_ONE - e) <<< FRAC_BITS;
         den    = Q30_ONE + e;
         tab[i] = TAB_W'(quotient_u(num + (den >>> 1), den));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

endpackage

// ===== sv/nau_interp.sv =====
// ----------------------------------------------------------------------------
// Tanh interpolation stages
// Three register stages: magnitude and segment split, table read with slope
// multiply, then interpolated tanh magnitude, sigmoid and leaky value.
// ----------------------------------------------------------------------------
module nau_interp
   import nau_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  op_type                        in_op,
   input  logic signed [DATA_WIDTH-1:0]  in_operand,
   input  kind_type                      in_kind,
   output interp_out_type                out
);

   // Stage 1 signals.
   logic              neg;
   logic [MAG_W-1:0]  operand_u;
   logic [MAG_W-1:0]  mag;
   logic              half_sel;
   logic [MAG_W-1:0]  idx_wide;
   logic [SEG_W-1:0]  idx;
   logic [MAG_W-1:0]  seg_base;

   logic              v1_ff, v1_in;
   item_ctl_type      ctl1_ff, ctl1_in;
   logic [SEG_W-1:0]  idx1_ff, idx1_in;
   logic [FRAC_W-1:0] frac1_ff, frac1_in;
   logic [MAG_W-1:0]  mag1_ff, mag1_in;

   // Stage 2 signals.
   logic [IDX_W-1:0]        idx_lo;
   logic [IDX_W-1:0]        idx_hi;
   logic [TAB_W-1:0]        tab_lo;
   logic [TAB_W-1:0]        tab_hi;
   logic [TAB_W-1:0]        slope;

   logic                    v2_ff, v2_in;
   item_ctl_type            ctl2_ff, ctl2_in;
   logic [TAB_W-1:0]        base2_ff, base2_in;
   logic [SLOPE_PROD_W-1:0] sprod2_ff, sprod2_in;
   logic [LEAK_PROD_W-1:0]  lprod2_ff, lprod2_in;

   // Stage 3 signals.
   logic [SLOPE_PROD_W-1:0] step;
   logic [TAB_W-1:0]        t_mag;
   logic [TAB_W:0]          sig_sum;
   logic [LEAK_PROD_W-1:0]  leak_round;
   interp_out_type          out_ff, out_in;

   // Stage 1: magnitude, segment index and offset within the segment.
   always_comb begin
      neg       = in_operand[DATA_WIDTH-1];
      operand_u = MAG_W'(in_operand);
      mag       = neg ? (~operand_u + MAG_W'(1)) : operand_u;
      half_sel  = (in_kind == KIND_SIGMOID);
      idx_wide  = half_sel ? (mag >> (SEG_SHIFT + 1)) : (mag >> SEG_SHIFT);
      if (idx_wide > MAG_W'(TABLE_SEGMENTS - 1)) begin
         idx = SEG_W'(TABLE_SEGMENTS - 1);
      end else begin
         idx = idx_wide[SEG_W-1:0];
      end
      seg_base = half_sel ? (MAG_W'(idx) << (SEG_SHIFT + 1)) : (MAG_W'(idx) << SEG_SHIFT);

      v1_in          = in_valid;
      ctl1_in.kind   = in_kind;
      ctl1_in.op     = in_op;
      ctl1_in.neg    = neg;
      ctl1_in.x      = in_operand;
      idx1_in        = idx;
      frac1_in       = FRAC_W'(mag - seg_base);
      mag1_in        = mag;
   end

   // Stage 2: breakpoint read and slope times offset.
   always_comb begin
      idx_lo    = IDX_W'(idx1_ff);
      idx_hi    = IDX_W'(idx1_ff) + IDX_W'(1);
      tab_lo    = TANH_TAB[idx_lo];
      tab_hi    = TANH_TAB[idx_hi];
      slope     = tab_hi - tab_lo;

      v2_in     = v1_ff;
      ctl2_in   = ctl1_ff;
      base2_in  = tab_lo;
      sprod2_in = SLOPE_PROD_W'(slope) * SLOPE_PROD_W'(frac1_ff);
      lprod2_in = LEAK_PROD_W'(mag1_ff) * LEAK_PROD_W'(LEAKY);
   end

   // Stage 3: interpolated magnitude, sigmoid and rounded leaky product.
   always_comb begin
      if (ctl2_ff.kind == KIND_SIGMOID) begin
         step = sprod2_ff >> (SEG_SHIFT + 1);
      end else begin
         step = sprod2_ff >> SEG_SHIFT;
      end
      t_mag = base2_ff + TAB_W'(step);
      if (ctl2_ff.neg) begin
         sig_sum = (TAB_W + 1)'(FIX_ONE) + (TAB_W + 1)'(1) - (TAB_W + 1)'(t_mag);
      end else begin
         sig_sum = (TAB_W + 1)'(FIX_ONE) + (TAB_W + 1)'(1) + (TAB_W + 1)'(t_mag);
      end
      leak_round = (lprod2_ff + LEAK_PROD_W'(FIX_HALF)) >> FRAC_BITS;

      out_in.valid = v2_ff;
      out_in.ctl   = ctl2_ff;
      out_in.t_mag = t_mag;
      out_in.sig   = sig_sum[TAB_W:1];
      out_in.leak  = LEAK_W'(leak_round);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         out_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl1_ff      <= ctl1_in;
      idx1_ff      <= idx1_in;
      frac1_ff     <= frac1_in;
      mag1_ff      <= mag1_in;
      ctl2_ff      <= ctl2_in;
      base2_ff     <= base2_in;
      sprod2_ff    <= sprod2_in;
      lprod2_ff    <= lprod2_in;
   end

   assign out = out_ff;

endmodule

// ===== sv/nau_post.sv =====
// ----------------------------------------------------------------------------
// Output stages
// Derivative product stage, then function selection, saturation and the
// output register.
// ----------------------------------------------------------------------------
module nau_post
   import nau_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  interp_out_type                in,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_result,
   output logic                          rsp_invalid_kind
);

   // Stage 4 signals.
   logic [TAB_W-1:0]     mul_a;
   logic [TAB_W-1:0]     mul_b;

   logic                 v4_ff, v4_in;
   item_ctl_type         ctl4_ff, ctl4_in;
   logic [TAB_W-1:0]     tmag4_ff, tmag4_in;
   logic [TAB_W-1:0]     sig4_ff, sig4_in;
   logic [LEAK_W-1:0]    leak4_ff, leak4_in;
   logic [SQ_PROD_W-1:0] sq4_ff, sq4_in;

   // Stage 5 signals.
   logic [SQ_PROD_W-1:0]     sq_round;
   logic signed [RES_W-1:0]  one_s;
   logic signed [RES_W-1:0]  x_s;
   logic signed [RES_W-1:0]  tmag_s;
   logic signed [RES_W-1:0]  sq_s;
   logic                     x_pos;
   logic signed [RES_W-1:0]  r;
   logic                     bad;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0]  rsp_result_ff, rsp_result_in;
   logic                          rsp_invalid_ff, rsp_invalid_in;

   // Stage 4: t*t for the tanh slope, s*(1-s) for the sigmoid slope.
   always_comb begin
      if (in.ctl.kind == KIND_SIGMOID) begin
         mul_a = in.sig;
         mul_b = FIX_ONE - in.sig;
      end else begin
         mul_a = in.t_mag;
         mul_b = in.t_mag;
      end
      v4_in    = in.valid;
      ctl4_in  = in.ctl;
      tmag4_in = in.t_mag;
      sig4_in  = in.sig;
      leak4_in = in.leak;
      sq4_in   = SQ_PROD_W'(mul_a) * SQ_PROD_W'(mul_b);
   end

   // Stage 5: pick the answer for the kind and opcode, then saturate.
   always_comb begin
      sq_round = (sq4_ff + SQ_PROD_W'(FIX_HALF)) >> FRAC_BITS;
      one_s    = $signed(RES_W'(FIX_ONE));
      x_s      = RES_W'(ctl4_ff.x);
      tmag_s   = $signed(RES_W'(tmag4_ff));
      sq_s     = $signed(RES_W'(sq_round));
      x_pos    = !ctl4_ff.neg && (ctl4_ff.x != '0);
      bad      = 1'b0;
      unique case (ctl4_ff.kind)
         KIND_TANH: begin
            if (ctl4_ff.op == OP_DERIV) begin
               r = one_s - sq_s;
            end else begin
               r = ctl4_ff.neg ? -tmag_s : tmag_s;
            end
         end
         KIND_SIGMOID: begin
            if (ctl4_ff.op == OP_DERIV) begin
               r = sq_s;
            end else begin
               r = $signed(RES_W'(sig4_ff));
            end
         end
         KIND_RELU: begin
            if (ctl4_ff.op == OP_DERIV) begin
               r = x_pos ? one_s : '0;
            end else begin
               r = x_pos ? x_s : '0;
            end
         end
         KIND_LEAKY: begin
            if (ctl4_ff.op == OP_DERIV) begin
               r = x_pos ? one_s : $signed(RES_W'(LEAKY));
            end else if (ctl4_ff.neg) begin
               r = -$signed(RES_W'(leak4_ff));
            end else begin
               r = x_s;
            end
         end
         KIND_LINEAR: begin
            r = (ctl4_ff.op == OP_DERIV) ? one_s : x_s;
         end
         default: begin
            r   = '0;
            bad = 1'b1;
         end
      endcase

      priority if (r > SAT_MAX) begin
         rsp_result_in = DATA_WIDTH'(SAT_MAX);
      end else if (r < SAT_MIN) begin
         rsp_result_in = DATA_WIDTH'(SAT_MIN);
      end else begin
         rsp_result_in = DATA_WIDTH'(r);
      end
      rsp_valid_in   = v4_ff;
      rsp_invalid_in = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl4_ff        <= ctl4_in;
      tmag4_ff       <= tmag4_in;
      sig4_ff        <= sig4_in;
      leak4_ff       <= leak4_in;
      sq4_ff         <= sq4_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_result_ff;
   assign rsp_invalid_kind = rsp_invalid_ff;

endmodule

// ===== sv/neural_activation_unit.sv =====
// ----------------------------------------------------------------------------
// Neural activation unit
// Applies tanh, sigmoid, ReLU, leaky ReLU or linear activation, or the
// derivative of it, to a stream of signed Q4.12 words.
// ----------------------------------------------------------------------------
// The unit takes one word in every clock cycle: busy is held low, so a word
// is taken at every rising edge at which start is high. Each word comes back
// on a one-cycle rsp_valid strobe, in the order it went in; the receiver
// cannot hold results back and must take each word in the cycle it is shown.
// Each word passes through the pipeline registers in order: segment split,
// table read with slope multiply, interpolation, derivative multiply, then
// selection and saturation into the output register. The user must write
// the activation kind through csr_write_enable and csr_write_data only
// while no word is in flight; the unit does not enforce this. The kind
// resets to tanh. An undefined kind returns zero with rsp_invalid_kind set.
// ----------------------------------------------------------------------------
module neural_activation_unit
   import nau_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic signed [DATA_WIDTH-1:0]  req_operand,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_write_data,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_result,
   output logic                          rsp_invalid_kind
);

   // Activation kind register. Codes five to seven are held as written and
   // flagged as invalid at the output stage.
   logic [2:0]     activation_kind_ff, activation_kind_in;

   interp_out_type interp_word;

   always_comb begin
      activation_kind_in = csr_write_enable ? csr_write_data : activation_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         activation_kind_ff <= 3'(KIND_TANH);
      end else begin
         activation_kind_ff <= activation_kind_in;
      end
   end

   // Every stage advances each cycle and nothing downstream can push back,
   // so the unit is never busy.
   assign busy = 1'b0;

   // Stages one to three: magnitude, tanh table interpolation, sigmoid and
   // the leaky ReLU product. The kind is sampled with the word so that it
   // travels down the pipeline alongside it.
   nau_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_op      (op_type'(req_opcode)),
      .in_operand (req_operand),
      .in_kind    (kind_type'(activation_kind_ff)),
      .out        (interp_word)
   );

   // Stages four and five: derivative product, function selection,
   // saturation and the output register.
   nau_post u_post (
      .clock            (clock),
      .reset            (reset),
      .in               (interp_word),
      .rsp_valid        (rsp_valid),
      .rsp_result       (rsp_result),
      .rsp_invalid_kind (rsp_invalid_kind)
   );

endmodule

// ===== sv/nau_checker.sv =====
// ----------------------------------------------------------------------------
// Neural activation unit checker
// Port-level assertions on latency, the invalid-kind flag and the linear
// pass-through, with the bind that attaches them to the top level.
// ----------------------------------------------------------------------------
module nau_checker
   import nau_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_opcode,
   input  logic signed [DATA_WIDTH-1:0]  req_operand,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_write_data,
   input  logic                          rsp_valid,
   input  logic signed [DATA_WIDTH-1:0]  rsp_result,
   input  logic                          rsp_invalid_kind
);

   localparam int AGE_W = $clog2(PIPE_LATENCY + 1);

   logic [2:0]       kind_ff, kind_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             settled;

   // Shadow of the kind register and a saturating count of cycles since reset.
   always_comb begin
      kind_in = csr_write_enable ? csr_write_data : kind_ff;
      age_in  = (age_ff == AGE_W'(PIPE_LATENCY)) ? age_ff : age_ff + AGE_W'(1);
      settled = (age_ff == AGE_W'(PIPE_LATENCY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 3'(KIND_TANH);
         age_ff  <= '0;
      end else begin
         kind_ff <= kind_in;
         age_ff  <= age_in;
      end
   end

   // The result strobe follows the record of accepted words once settled.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      settled |-> (rsp_valid == $past(start && !busy, PIPE_LATENCY)))
      else $error("result strobe does not match accepted word");

   // An undefined kind always returns zero.
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_kind) |-> (rsp_result == '0))
      else $error("invalid kind returned a non-zero result");

   // The flag follows the programmed kind.
   a_invalid_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_invalid_kind == (kind_ff > 3'(KIND_LINEAR))))
      else $error("invalid kind flag disagrees with programmed kind");

   // Linear value passes the operand through unchanged.
   a_linear : assert property (@(posedge clock) disable iff (reset)
      (settled && rsp_valid && (kind_ff == 3'(KIND_LINEAR))
         && ($past(req_opcode, PIPE_LATENCY) == OP_VALUE))
      |-> (rsp_result == $past(req_operand, PIPE_LATENCY)))
      else $error("linear result differs from operand");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (.*);

// ===== sim/neural_activation_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neural activation unit testbench
// Streams signed Q4.12 words with random opcodes through every activation
// kind, including the undefined codes, and checks each result word against
// a bit-exact fixed-point prediction of tanh, sigmoid, ReLU, leaky ReLU and
// linear values and derivatives.
// ----------------------------------------------------------------------------
module neural_activation_unit_tb;
   import nau_pkg::*;

   // Kind codes that the package leaves undefined; the unit must flag them.
   localparam logic [2:0] KIND_UNDEF5 = 3'd5;
   localparam logic [2:0] KIND_UNDEF6 = 3'd6;
   localparam logic [2:0] KIND_UNDEF7 = 3'd7;

   // Fixed-point constants of the prediction, all in 64-bit arithmetic.
   localparam longint FIX_UNIT    = longint'(1) <<< FRAC_BITS;
   localparam longint LEAK_SLOPE  = (FIX_UNIT + 5) / 10;
   localparam longint HALF_SPAN   = longint'(1) <<< (DATA_WIDTH - 1);
   localparam longint Q30_UNIT    = longint'(1) <<< 30;
   localparam longint RECIP_E_Q30 = 395007543;

   localparam int RESET_CYCLES   = 9;
   localparam int PHASE_WORDS    = 100;
   localparam int WATCHDOG_LIMIT = 2000;

   // One word waiting to be offered to the unit.
   typedef struct packed {
      op_type                       op;
      logic signed [DATA_WIDTH-1:0] operand;
   } stim_word_type;

   // The answer predicted for one accepted word; op and operand are kept so
   // that a mismatch report says which word went wrong.
   typedef struct packed {
      op_type                       op;
      logic signed [DATA_WIDTH-1:0] operand;
      logic signed [DATA_WIDTH-1:0] result;
      logic                         invalid_kind;
   } answer_type;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         start            = 1'b0;
   logic                         busy;
   logic                         req_opcode       = OP_VALUE;
   logic signed [DATA_WIDTH-1:0] req_operand      = '0;
   logic                         csr_write_enable = 1'b0;
   logic [2:0]                   csr_write_data   = KIND_TANH;
   logic                         rsp_valid;
   logic signed [DATA_WIDTH-1:0] rsp_result;
   logic                         rsp_invalid_kind;

   // Our own copy of the activation kind register and of the tanh table.
   logic [2:0] model_kind = KIND_TANH;
   longint     tanh_knots [0:TABLE_SEGMENTS];

   stim_word_type queued_words [$];
   answer_type    awaited_answers [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int gap_left       = 0;
   int calm_left      = 0;
   bit calm           = 1'b0;

   // Corner operands: both ends of the range, the values either side of
   // zero, and the most negative value, whose magnitude falls off the table.
   logic signed [DATA_WIDTH-1:0] corner_operands [6] = '{
      16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF
   };

   // Directed opening words: range ends, zero and its neighbours, the tanh
   // breakpoints +-512 and 32256, 511, plus and minus one (+-4096), 20000.
   logic signed [DATA_WIDTH-1:0] opening_operands [12] = '{
      16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1, 16'sd512,
      -16'sd512, 16'sd511, 16'sd4096, -16'sd4096, 16'sd32256, 16'sd20000
   };

   // Order in which the register is set for the random phases. Every code
   // from 0 to 7 appears, and several come back more than once.
   logic [2:0] kind_plan [12] = '{
      KIND_SIGMOID, KIND_RELU, KIND_LEAKY, KIND_LINEAR, KIND_UNDEF5, KIND_TANH,
      KIND_UNDEF7, KIND_LEAKY, KIND_UNDEF6, KIND_SIGMOID, KIND_TANH, KIND_RELU
   };

   neural_activation_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_operand      (req_operand),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_result       (rsp_result),
      .rsp_invalid_kind (rsp_invalid_kind)
   );

   always #6 clock = ~clock;

   // Raw magnitude at which breakpoint i of the tanh table sits.
   function automatic longint knot_pos(input longint i);
      return (i * HALF_SPAN) / TABLE_SEGMENTS;
   endfunction

   // Tanh of the magnitude m scaled down by 2^halve, with halve either 0 or
   // 1. Interpolation truncates towards zero. A magnitude beyond the table,
   // which only the most negative operand produces, stays in the last
   // segment, and a segment of zero width gives its left value unchanged.
   function automatic longint tanh_interp(input longint m, input int halve);
      longint seg;
      longint lo;
      longint hi;
      seg = (m * TABLE_SEGMENTS) / (HALF_SPAN <<< halve);
      if (seg > TABLE_SEGMENTS - 1) begin
         seg = TABLE_SEGMENTS - 1;
      end
      lo = knot_pos(seg) <<< halve;
      hi = knot_pos(seg + 1) <<< halve;
      if (hi <= lo || m <= lo) begin
         return tanh_knots[seg];
      end
      return tanh_knots[seg] +
             ((tanh_knots[seg + 1] - tanh_knots[seg]) * (m - lo)) / (hi - lo);
   endfunction

   // Predicted result of one word under the given activation kind.
   function automatic answer_type activation_answer(input logic [2:0] kind, input op_type op,
                                                    input logic signed [DATA_WIDTH-1:0] x);
      answer_type ans;
      longint  xv;
      longint  m;
      longint  t;
      longint  s;
      longint  r;
      logic    neg;
      neg = x[DATA_WIDTH-1];
      xv  = longint'(x);
      m   = neg ? -xv : xv;
      r   = 0;
      ans.op           = op;
      ans.operand      = x;
      ans.invalid_kind = 1'b0;
      case (kind)
         KIND_TANH: begin
            t = tanh_interp(m, 0);
            if (neg) begin
               t = -t;
            end
            r = (op == OP_DERIV) ? FIX_UNIT - ((t * t + FIX_UNIT / 2) >>> FRAC_BITS) : t;
         end
         KIND_SIGMOID: begin
            // Sigmoid folds onto tanh of half the operand.
            t = tanh_interp(m, 1);
            if (neg) begin
               t = -t;
            end
            s = (FIX_UNIT + t + 1) >>> 1;
            r = (op == OP_DERIV) ? (s * (FIX_UNIT - s) + FIX_UNIT / 2) >>> FRAC_BITS : s;
         end
         KIND_RELU: begin
            if (op == OP_DERIV) begin
               r = (xv > 0) ? FIX_UNIT : 0;
            end else begin
               r = (xv > 0) ? xv : 0;
            end
         end
         KIND_LEAKY: begin
            if (op == OP_DERIV) begin
               r = (xv > 0) ? FIX_UNIT : LEAK_SLOPE;
            end else if (neg) begin
               r = -((m * LEAK_SLOPE + FIX_UNIT / 2) >>> FRAC_BITS);
            end else begin
               r = xv;
            end
         end
         KIND_LINEAR: begin
            r = (op == OP_DERIV) ? FIX_UNIT : xv;
         end
         default: begin
            r = 0;
            ans.invalid_kind = 1'b1;
         end
      endcase
      if (r > HALF_SPAN - 1) begin
         r = HALF_SPAN - 1;
      end else if (r < -HALF_SPAN) begin
         r = -HALF_SPAN;
      end
      ans.result = DATA_WIDTH'(r);
      return ans;
   endfunction

   // Waits until no word is queued, offered or in flight in the unit.
   task automatic wait_drained();
      @(negedge clock);
      while (queued_words.size() != 0 || start || awaited_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Driver. A word leaves the queue when the previous one has been taken
   // and the drawn gap has run out. Gaps come in stretches: some stretches
   // offer back to back, others draw a random gap for each word.
   always @(posedge clock) begin : driver
      stim_word_type w;
      logic          hold;
      if (reset) begin
         start    <= 1'b0;
         gap_left  = 0;
      end else begin
         hold = start;
         if (start && !busy) begin
            awaited_answers.push_back(
               activation_answer(model_kind, op_type'(req_opcode), req_operand));
            hold = 1'b0;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (queued_words.size() != 0) begin
               w = queued_words.pop_front();
               req_opcode  <= w.op;
               req_operand <= w.operand;
               start       <= 1'b1;
               if (calm_left == 0) begin
                  calm_left = $urandom_range(10, 60);
                  calm      = ($urandom_range(0, 2) == 0);
               end
               calm_left--;
               gap_left = calm ? 0 : $urandom_range(0, 10);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each strobed result word is matched against the oldest
   // prediction. The watchdog counts cycles in which neither side moved a
   // word, and gives up when the unit has plainly stopped.
   always @(posedge clock) begin : monitor
      answer_type a;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: result word with none expected: result %0d, invalid_kind %0b",
                        $time, rsp_result, rsp_invalid_kind);
               mismatch_count++;
            end else begin
               a = awaited_answers.pop_front();
               if (rsp_result !== a.result) begin
                  $display("%0t: result for operand %0d op %0d: expected %0d, actual %0d",
                           $time, a.operand, a.op, a.result, rsp_result);
                  mismatch_count++;
               end
               if (rsp_invalid_kind !== a.invalid_kind) begin
                  $display("%0t: invalid_kind for operand %0d: expected %0b, actual %0b",
                           $time, a.operand, a.invalid_kind, rsp_invalid_kind);
                  mismatch_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Sequencer: builds the tanh table, releases reset, runs the directed
   // opening under the reset kind, then one random phase per planned kind.
   initial begin : sequencer
      longint        u;
      longint        whole;
      longint        part;
      longint        acc;
      longint        step;
      longint        num;
      longint        den;
      int            i;
      int            k;
      int            n;
      int            p;
      logic signed [DATA_WIDTH-1:0] v;
      stim_word_type w;

      // Tanh at each breakpoint: exp(-2b) in Q30 from a series up to x^20 for
      // the fraction and repeated multiplication by 1/e for the whole part.
      for (i = 0; i <= TABLE_SEGMENTS; i++) begin
         u     = 2 * knot_pos(i);
         whole = u >>> FRAC_BITS;
         part  = u & (FIX_UNIT - 1);
         acc   = Q30_UNIT;
         step  = Q30_UNIT;
         for (k = 1; k <= 20; k++) begin
            step = ((step * part) >>> FRAC_BITS) / k;
            acc  = (k % 2 == 1) ? acc - step : acc + step;
         end
         if (whole >= 64) begin
            acc = 0;
         end else begin
            repeat (whole) acc = (acc * RECIP_E_Q30 + Q30_UNIT / 2) >>> 30;
         end
         num           = (Q30_UNIT - acc) <<< FRAC_BITS;
         den           = Q30_UNIT + acc;
         tanh_knots[i] = (num + den / 2) / den;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, both opcodes on every word, under the reset kind.
      @(negedge clock);
      foreach (opening_operands[j]) begin
         w.operand = opening_operands[j];
         w.op      = OP_VALUE;
         queued_words.push_back(w);
         w.op      = OP_DERIV;
         queued_words.push_back(w);
      end

      foreach (kind_plan[ph]) begin
         // The register may only change while nothing is in flight.
         wait_drained();
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= kind_plan[ph];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         @(negedge clock);
         model_kind = kind_plan[ph];

         for (n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  v = corner_operands[$urandom_range(0, 5)];
               end
               1, 2: begin
                  // On or next to a multiple of 256, half a tanh segment.
                  p = $urandom_range(0, 128) * 256 + $urandom_range(0, 2) - 1;
                  if ($urandom_range(0, 1) == 1) begin
                     p = -p;
                  end
                  v = DATA_WIDTH'(p);
               end
               3, 4: begin
                  // Near zero, where the curves bend hardest.
                  p = $urandom_range(0, 2400);
                  v = DATA_WIDTH'(p - 1200);
               end
               default: begin
                  v = DATA_WIDTH'($urandom);
               end
            endcase
            w.operand = v;
            w.op      = op_type'($urandom_range(0, 1));
            queued_words.push_back(w);
         end
      end

      wait_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/nau_pkg.sv
sv/nau_interp.sv
sv/nau_post.sv
sv/neural_activation_unit.sv
sv/nau_checker.sv
sim/neural_activation_unit_tb.sv
